@@ hw/rtl/msr_pkg.sv @@
// Shared types, codes and widths for the motor speed ramp.
// No dependencies; the RTL files refer to it by scoped names, the testbench imports it.
package msr_pkg;

  localparam int SPEED_W = 16;
  localparam int DIR_W   = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_ADDR_W = 1;

  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
  localparam logic [SPEED_W-1:0] STEP_RESET = 16'd16;
  localparam logic [SPEED_W-1:0] MIN_DRIVE_RESET = 16'd0;

  typedef enum logic [DIR_W-1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BWD  = 2'd2
  } dir_t;

  typedef enum logic {
    OP_SET  = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_STEP_SIZE = 1'b0,
    CFG_MIN_DRIVE = 1'b1
  } cfg_idx_t;

  // Motion state: where the motor is and where it is headed.
  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    dir_t               dir;
    logic [SPEED_W-1:0] goal_speed;
    dir_t               goal_dir;
  } motion_t;

  // Configuration values seen by the ramp logic.
  typedef struct packed {
    logic [SPEED_W-1:0] step_size;
    logic [SPEED_W-1:0] min_drive;
  } cfg_t;

  // Outcome of one tick.
  typedef struct packed {
    logic               active;
    logic [SPEED_W-1:0] speed;
    dir_t               dir;
    logic               settled;
  } tick_t;

  // Map a raw direction code onto a legal direction; the unused code means stop.
  function automatic dir_t to_dir(input logic [DIR_W-1:0] code);
    dir_t d;
    case (code)
      DIR_FWD: d = DIR_FWD;
      DIR_BWD: d = DIR_BWD;
      default: d = DIR_STOP;
    endcase
    return d;
  endfunction

endpackage

@@ hw/rtl/msr_cfg_regs.sv @@
// Configuration registers of the motor speed ramp: step size and minimum drive.
// Depends on msr_pkg.
module msr_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [msr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [msr_pkg::SPEED_W-1:0]       cfg_wdata,
  output msr_pkg::cfg_t                     cfg
);

  logic [msr_pkg::SPEED_W-1:0] step_r;
  logic [msr_pkg::SPEED_W-1:0] min_r;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= msr_pkg::STEP_RESET;
      min_r  <= msr_pkg::MIN_DRIVE_RESET;
    end else if (cfg_we) begin
      case (msr_pkg::cfg_idx_t'(cfg_addr))
        msr_pkg::CFG_STEP_SIZE: step_r <= cfg_wdata;
        msr_pkg::CFG_MIN_DRIVE: min_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg.step_size = step_r;
  assign cfg.min_drive = min_r;

endmodule

@@ hw/rtl/msr_ramp_calc.sv @@
// One ramp tick: slew the current speed toward the goal, reversing via a slow-down.
// Depends on msr_pkg; purely combinational.
module msr_ramp_calc (
  input  msr_pkg::motion_t  cur,
  input  msr_pkg::cfg_t     cfg,
  output msr_pkg::tick_t    tick
);

  logic [msr_pkg::SPEED_W-1:0] min_plus;
  logic [msr_pkg::SPEED_W-1:0] up_diff;
  logic [msr_pkg::SPEED_W-1:0] dn_diff;
  logic [msr_pkg::SPEED_W-1:0] nspd;
  msr_pkg::dir_t               ndir;

  // Speed loaded when the direction flips; one above minimum unless stopping or the minimum is the largest speed
  always_comb begin
    min_plus = cfg.min_drive;
    if (cur.goal_dir != msr_pkg::DIR_STOP && cfg.min_drive != msr_pkg::SPEED_MAX)
      min_plus = cfg.min_drive + 16'd1;
  end

  assign up_diff = cur.goal_speed - cur.speed;
  assign dn_diff = cur.speed - cur.goal_speed;

  // Next speed and direction
  always_comb begin
    nspd = cur.speed;
    ndir = cur.dir;
    if (cur.dir != cur.goal_dir) begin
      if (cur.speed < cfg.step_size) begin
        nspd = min_plus;
        ndir = cur.goal_dir;
      end else begin
        nspd = cur.speed - cfg.step_size;
      end
    end else if (cur.speed < cur.goal_speed) begin
      if (up_diff < cfg.step_size) nspd = cur.goal_speed;
      else                         nspd = cur.speed + cfg.step_size;
    end else begin
      if (dn_diff < cfg.step_size) nspd = cur.goal_speed;
      else                         nspd = cur.speed - cfg.step_size;
    end
  end

  assign tick.active  = (cur.speed != cur.goal_speed) || (cur.dir != cur.goal_dir);
  assign tick.speed   = nspd;
  assign tick.dir     = ndir;
  assign tick.settled = (nspd == cur.goal_speed) && (ndir == cur.goal_dir);

endmodule

@@ hw/rtl/motor_speed_ramp.sv @@
// Top level of the motor speed ramp: input register, motion state, result register.
// Depends on msr_pkg, msr_cfg_regs and msr_ramp_calc.
//
//  channel | dir | beat contents
//  in_     | in  | tuser = op (0 set target, 1 tick); tdata = target speed, direction
//  out_    | out | tdata = drive speed, drive direction, settled
//  cfg_    | in  | write-only: 0 step size, 1 minimum drive
//
// A taken beat waits in the input register and is resolved into the motion state and result
// register once that register can take a new value; one beat per cycle unless the result stalls.
// The motion state and result register update together, so back-to-back ticks chain.
// A stalled result holds the input register; a set beat or a settled tick gives no result.
// Synchronous active-low reset: speeds zero, directions stopped, step 16, minimum 0.
module motor_speed_ramp (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [msr_pkg::IN_DATA_W-1:0]       in_tdata,   // [15:0] target_speed, [17:16] target_dir
  input  logic                                in_tuser,   // [0] op
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [msr_pkg::OUT_DATA_W-1:0]      out_tdata,  // [15:0] drive_speed, [17:16] drive_dir, [18] settled
  // configuration
  input  logic                                cfg_we,
  input  logic [msr_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [msr_pkg::SPEED_W-1:0]         cfg_wdata
);

  msr_pkg::cfg_t    cfg;
  msr_pkg::motion_t mot_r;
  msr_pkg::motion_t mot_nxt;
  msr_pkg::tick_t   tick;

  logic                        in_valid_r;
  msr_pkg::op_t                in_op_r;
  logic [msr_pkg::SPEED_W-1:0] in_speed_r;
  logic [msr_pkg::DIR_W-1:0]   in_dir_r;

  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic [msr_pkg::SPEED_W-1:0] out_speed_r;
  msr_pkg::dir_t               out_dir_r;
  logic                        out_settled_r;

  logic proceed;
  logic fire;
  logic emit;

  msr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  msr_ramp_calc u_calc (
    .cur  (mot_r),
    .cfg  (cfg),
    .tick (tick)
  );

  // Resolve the held beat whenever the result register can take a new value
  assign proceed   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && proceed;
  assign emit      = fire && (in_op_r == msr_pkg::OP_TICK) && tick.active;
  assign in_tready = !in_valid_r || proceed;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_op_r    <= msr_pkg::op_t'(in_tuser);
      in_speed_r <= in_tdata[msr_pkg::SPEED_W-1:0];
      in_dir_r   <= in_tdata[msr_pkg::SPEED_W +: msr_pkg::DIR_W];
    end
  end

  // Motion state update: set beats load the goal, ticks advance the speed
  always_comb begin
    mot_nxt = mot_r;
    if (fire) begin
      case (in_op_r)
        msr_pkg::OP_SET: begin
          mot_nxt.goal_speed = in_speed_r;
          mot_nxt.goal_dir   = msr_pkg::to_dir(in_dir_r);
        end
        msr_pkg::OP_TICK: begin
          if (tick.active) begin
            mot_nxt.speed = tick.speed;
            mot_nxt.dir   = tick.dir;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mot_r.speed      <= '0;
      mot_r.dir        <= msr_pkg::DIR_STOP;
      mot_r.goal_speed <= '0;
      mot_r.goal_dir   <= msr_pkg::DIR_STOP;
    end else begin
      mot_r <= mot_nxt;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (proceed) out_valid_nxt = emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_speed_r   <= tick.speed;
      out_dir_r     <= tick.dir;
      out_settled_r <= tick.settled;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_settled_r, out_dir_r, out_speed_r};

endmodule

@@ hw/rtl/msr_checker.sv @@
// Port-level checks for the motor speed ramp, bound to the top level.
// Depends on msr_pkg and motor_speed_ramp.
module msr_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [msr_pkg::OUT_DATA_W-1:0]      out_tdata
);

  // A stalled result beat holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Reset empties both registers
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not empty after reset");

  // Drive direction is never the unused code
  a_dir_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[17:16] != 2'd3)
    else $error("illegal drive direction");

  // With the result side free, input is always taken
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty result register");

endmodule

bind motor_speed_ramp msr_checker u_msr_checker (.*);

@@ sim/motor_speed_ramp_test.sv @@
// Self-checking testbench for motor_speed_ramp: random and directed set/tick beats,
// a beat-by-beat ramp predictor and a field-by-field result check.
// Depends on msr_pkg and the motor_speed_ramp RTL.
module motor_speed_ramp_test;
  import msr_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [DIR_W-1:0] DIR_CODE_UNUSED = 2'd3;

  typedef struct packed {
    op_t                op;
    logic [SPEED_W-1:0] speed;
    logic [DIR_W-1:0]   dir;
  } cmd_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    dir_t               dir;
    logic               settled;
  } drive_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [SPEED_W-1:0] cfg_wdata = '0;

  // Stimulus and expected drive results
  cmd_t   cmd_queue[$];
  drive_t drive_expected[$];
  int     cmds_pushed = 0;
  int     cmds_taken = 0;
  int     fail_count = 0;
  int     cycle_cnt = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;

  // Predicted motion state and configuration
  logic [SPEED_W-1:0] cur_speed = '0;
  dir_t               cur_dir = DIR_STOP;
  logic [SPEED_W-1:0] goal_speed = '0;
  dir_t               goal_dir = DIR_STOP;
  logic [SPEED_W-1:0] step_size = STEP_RESET;
  logic [SPEED_W-1:0] min_drive = MIN_DRIVE_RESET;

  motor_speed_ramp dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [15:0] target_speed, [17:16] target_dir
    .in_tuser   (in_tuser),   // [0] op
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [15:0] drive_speed, [17:16] drive_dir, [18] settled
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Apply one accepted beat to the ramp state; queue a drive result when a tick moves it
  function automatic void advance_ramp(cmd_t c);
    logic [SPEED_W-1:0] nxt;
    drive_t r;
    if (c.op == OP_SET) begin
      goal_speed = c.speed;
      goal_dir = (c.dir == DIR_CODE_UNUSED) ? DIR_STOP : dir_t'(c.dir);
      return;
    end
    if (cur_speed == goal_speed && cur_dir == goal_dir) return;
    if (cur_dir != goal_dir) begin
      // slow down first; reverse once below one step
      if (cur_speed < step_size) begin
        nxt = min_drive;
        if (goal_dir != DIR_STOP && nxt != SPEED_MAX) nxt = nxt + 1'b1;
        cur_dir = goal_dir;
      end else begin
        nxt = cur_speed - step_size;
      end
    end else if (cur_speed < goal_speed) begin
      nxt = (goal_speed - cur_speed < step_size) ? goal_speed : cur_speed + step_size;
    end else begin
      nxt = (cur_speed - goal_speed < step_size) ? goal_speed : cur_speed - step_size;
    end
    cur_speed = nxt;
    r.speed = cur_speed;
    r.dir = cur_dir;
    r.settled = (cur_speed == goal_speed && cur_dir == goal_dir);
    drive_expected.push_back(r);
  endfunction

  // Driver: hold a beat until taken, then offer the next one unless idling
  always @(posedge clk) begin : driver
    cmd_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        advance_ramp(cmd_t'{op_t'(in_tuser), in_tdata[15:0], in_tdata[17:16]});
        cmds_taken = cmds_taken + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          c = cmd_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= c.op;
          in_tdata <= {{(IN_DATA_W - SPEED_W - DIR_W){1'b0}}, c.dir, c.speed};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest expectation
  always @(posedge clk) begin : monitor
    drive_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (drive_expected.size() == 0) begin
          $error("unexpected result beat: drive_speed %0d drive_dir %0d settled %0d",
                 out_tdata[15:0], out_tdata[17:16], out_tdata[18]);
          fail_count++;
        end else begin
          e = drive_expected.pop_front();
          if (out_tdata[15:0] !== e.speed) begin
            $error("drive_speed: expected %0d, got %0d", e.speed, out_tdata[15:0]);
            fail_count++;
          end
          if (out_tdata[17:16] !== e.dir) begin
            $error("drive_dir: expected %0d, got %0d", e.dir, out_tdata[17:16]);
            fail_count++;
          end
          if (out_tdata[18] !== e.settled) begin
            $error("settled: expected %0d, got %0d", e.settled, out_tdata[18]);
            fail_count++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void push_set(logic [SPEED_W-1:0] spd, logic [DIR_W-1:0] dir);
    cmd_queue.push_back(cmd_t'{OP_SET, spd, dir});
    cmds_pushed++;
  endfunction

  // Tick beats carry random, ignored payload
  function automatic void push_ticks(int n);
    for (int i = 0; i < n; i++) begin
      cmd_queue.push_back(cmd_t'{OP_TICK, SPEED_W'($urandom), DIR_W'($urandom)});
      cmds_pushed++;
    end
  endfunction

  function automatic logic [SPEED_W-1:0] pick_speed();
    case ($urandom_range(7))
      0: return '0;
      1: return SPEED_MAX;
      2: return SPEED_W'($urandom_range(255));
      default: return SPEED_W'($urandom);
    endcase
  endfunction

  // Wait until every beat is taken and every result is back, then let the pipe empty
  task automatic drain();
    while (cmds_taken != cmds_pushed || drive_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [SPEED_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_STEP_SIZE) step_size = val;
    else min_drive = val;
  endtask

  initial begin : timeout
    wait (cycle_cnt >= LIMIT_CYCLES);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int cnt;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, ramp up, settled tick, redundant set, unused code
    send_idle_pct = 15;
    recv_idle_pct = 76;
    push_set(16'd40, DIR_FWD);
    push_ticks(5);
    push_set(16'd40, DIR_FWD);
    push_ticks(1);
    push_set(16'd0, DIR_CODE_UNUSED);
    push_ticks(4);
    drain();

    // Directed: largest step and minimum, saturating reversal
    write_cfg(CFG_STEP_SIZE, SPEED_MAX);
    write_cfg(CFG_MIN_DRIVE, SPEED_MAX);
    push_set(SPEED_MAX, DIR_BWD);
    push_ticks(2);
    push_set(16'd0, DIR_FWD);
    push_ticks(4);
    drain();

    // Directed: unit step, zero minimum
    write_cfg(CFG_STEP_SIZE, 16'd1);
    write_cfg(CFG_MIN_DRIVE, 16'd0);
    push_set(16'd3, DIR_BWD);
    push_ticks(3);
    push_set(16'd0, DIR_STOP);
    push_ticks(4);

    // Random: three idling patterns, several settings each
    for (int ph = 0; ph < 3; ph++) begin
      for (int blk = 0; blk < 4; blk++) begin
        drain();
        send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 76 : 0;
        recv_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 15 : 0;
        case ($urandom_range(3))
          0: write_cfg(CFG_STEP_SIZE, SPEED_W'($urandom_range(1, 16)));
          1: write_cfg(CFG_STEP_SIZE, SPEED_MAX);
          default: write_cfg(CFG_STEP_SIZE, SPEED_W'($urandom_range(1000, 65535)));
        endcase
        write_cfg(CFG_MIN_DRIVE, ($urandom_range(3) == 0) ? SPEED_MAX : pick_speed());
        cnt = 0;
        while (cnt < 92) begin
          // mostly a new target followed by a burst of ticks; some stray beats
          case ($urandom_range(7))
            0: begin
              push_ticks(1);
              cnt += 1;
            end
            1: begin
              push_set(pick_speed(), DIR_W'($urandom));
              push_set(pick_speed(), DIR_W'($urandom));
              cnt += 2;
            end
            default: begin
              int n;
              n = $urandom_range(1, 8);
              push_set(pick_speed(), DIR_W'($urandom));
              push_ticks(n);
              cnt += n + 1;
            end
          endcase
        end
      end
    end

    drain();
    if (fail_count == 0 && drive_expected.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
